@@ src/sia_pkg.sv @@
// Shared types, constants and a search helper for the slot identifier allocator.
package sia_pkg;

    localparam int SLOTS     = 256;
    localparam int CELL_BITS = 64;
    localparam int CELLS     = SLOTS / CELL_BITS;
    localparam int FIELD_W   = 9;
    localparam int ID_W      = $clog2(SLOTS + 1);
    localparam int POS_W     = $clog2(SLOTS);
    localparam int OFF_W     = $clog2(CELL_BITS);
    localparam int CELL_W    = POS_W - OFF_W;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_FIRST = 2'd2,
        OP_NEXT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t                operation;
        logic [FIELD_W-1:0] entity_index;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] result_id;
        logic [FIELD_W-1:0] live_count;
    } rsp_t;

    typedef struct packed {
        op_t              op;
        logic             tgt_valid;
        logic [POS_W-1:0] tgt_pos;
        logic [POS_W-1:0] scan_pos;
        logic             scan_none;
    } cmd_t;

    typedef struct packed {
        logic            valid;
        logic            found;
        logic [ID_W-1:0] id;
        logic            hit;
    } tok_t;

    typedef struct packed {
        logic             en;
        logic             set;
        logic [POS_W-1:0] pos;
    } wr_t;

    function automatic logic [OFF_W-1:0] lowest_set(input logic [CELL_BITS-1:0] vec);
        logic [OFF_W-1:0] idx;
        idx = '0;
        for (int i = CELL_BITS - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                idx = OFF_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ src/sia_cell.sv @@
// One cell of the occupancy chain: a slice of the bitmap and one search step.
module sia_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [sia_pkg::CELL_W-1:0] base,
    input  sia_pkg::cmd_t              cmd,
    input  sia_pkg::wr_t               wr,
    input  sia_pkg::tok_t              tok_in,
    output sia_pkg::tok_t              tok_out
);
    import sia_pkg::*;

    logic [CELL_BITS-1:0] bits_reg;
    logic [CELL_BITS-1:0] bits_next;
    tok_t                 tok_reg;
    tok_t                 tok_next;

    logic [CELL_BITS-1:0] scan_mask;
    logic [CELL_BITS-1:0] search_vec;
    logic [OFF_W-1:0]     local_idx;
    logic                 local_found;
    logic                 tgt_here;
    logic                 tgt_bit;
    logic                 local_hit;

    logic [CELL_W-1:0] scan_cell;
    logic [OFF_W-1:0]  scan_off;

    assign scan_cell = cmd.scan_pos[POS_W-1:OFF_W];
    assign scan_off  = cmd.scan_pos[OFF_W-1:0];

    always_comb
    begin
        if (base > scan_cell)
        begin
            scan_mask = '1;
        end
        else if (base == scan_cell)
        begin
            scan_mask = ~((CELL_BITS'(1) << scan_off) - CELL_BITS'(1));
        end
        else
        begin
            scan_mask = '0;
        end
    end

    assign search_vec  = (cmd.op == OP_ALLOC) ? ~bits_reg : (bits_reg & scan_mask);
    assign local_found = |search_vec;
    assign local_idx   = lowest_set(search_vec);

    assign tgt_here  = cmd.tgt_valid && (cmd.tgt_pos[POS_W-1:OFF_W] == base);
    assign tgt_bit   = bits_reg[cmd.tgt_pos[OFF_W-1:0]];
    assign local_hit = tgt_here && ((cmd.op == OP_ALLOC) ? !tgt_bit : tgt_bit);

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.valid = tok_in.valid;
        if (tok_in.valid)
        begin
            tok_next.hit = tok_in.hit | local_hit;
            if (!tok_in.found && local_found)
            begin
                tok_next.found = 1'b1;
                tok_next.id    = ID_W'({base, local_idx}) + ID_W'(1);
            end
        end
    end

    always_comb
    begin
        bits_next = bits_reg;
        if (wr.en && (wr.pos[POS_W-1:OFF_W] == base))
        begin
            bits_next[wr.pos[OFF_W-1:0]] = wr.set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ src/slot_id_allocator.sv @@
// Slot identifier allocator: command sequencer over a chain of bitmap cells.
// An accepted request passes the launch register, the cell registers and fin_reg, then waits in ST_DONE for rsp_reg.
// Requests are taken one at a time, only in ST_IDLE; the token walks the 4-cell chain one cell a cycle.
// The response register frees the chain, so a request may enter while a response waits.
// Reset: rst_n clears the occupancy bitmap, live count and launch, token and response valid flags at once.
module slot_id_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sia_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sia_pkg::rsp_t rsp
);
    import sia_pkg::*;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    tok_t            launch_reg, launch_next;
    tok_t            fin_reg, fin_next;
    logic [ID_W-1:0] live_reg, live_next;
    rsp_t            rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;
    wr_t             wr;

    tok_t            tok [CELLS+1];

    logic [ID_W-1:0]  live_dec;
    logic [ID_W-1:0]  id_dec;
    logic [ID_W-1:0]  fin_dec;
    logic [POS_W-1:0] alloc_pos;

    assign tok[0] = launch_reg;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        sia_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .base    (CELL_W'(k)),
            .cmd     (cmd_reg),
            .wr      (wr),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    assign live_dec  = live_reg - ID_W'(1);
    assign id_dec    = ID_W'(req.entity_index) - ID_W'(1);
    assign fin_dec   = fin_reg.id - ID_W'(1);
    assign alloc_pos = fin_reg.hit ? cmd_reg.tgt_pos : fin_dec[POS_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        launch_next    = '0;
        fin_next       = fin_reg;
        live_next      = live_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        wr             = '0;
        req_ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next           = '0;
                    cmd_next.op        = req.operation;
                    case (req.operation)
                        OP_ALLOC:
                        begin
                            cmd_next.tgt_valid = (live_reg != '0) &&
                                                 (live_reg < ID_W'(SLOTS));
                            cmd_next.tgt_pos   = live_dec[POS_W-1:0];
                        end
                        OP_FREE:
                        begin
                            cmd_next.tgt_valid = (req.entity_index != '0) &&
                                                 (ID_W'(req.entity_index) <= ID_W'(SLOTS));
                            cmd_next.tgt_pos   = id_dec[POS_W-1:0];
                        end
                        OP_FIRST:
                        begin
                            cmd_next.scan_pos = '0;
                        end
                        OP_NEXT:
                        begin
                            cmd_next.scan_none = ID_W'(req.entity_index) >= ID_W'(SLOTS);
                            cmd_next.scan_pos  = req.entity_index[POS_W-1:0];
                        end
                        default:
                        begin
                            cmd_next.scan_pos = '0;
                        end
                    endcase
                    launch_next.valid = 1'b1;
                    state_next        = ST_BUSY;
                end
            end

            ST_BUSY:
            begin
                if (tok[CELLS].valid)
                begin
                    fin_next   = tok[CELLS];
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.result_id = '0;
                    case (cmd_reg.op)
                        OP_ALLOC:
                        begin
                            if (live_reg < ID_W'(SLOTS))
                            begin
                                wr.en              = 1'b1;
                                wr.set             = 1'b1;
                                wr.pos             = alloc_pos;
                                rsp_next.result_id = FIELD_W'(ID_W'(alloc_pos) + ID_W'(1));
                                live_next          = live_reg + ID_W'(1);
                            end
                        end
                        OP_FREE:
                        begin
                            if (fin_reg.hit)
                            begin
                                wr.en     = 1'b1;
                                wr.set    = 1'b0;
                                wr.pos    = cmd_reg.tgt_pos;
                                live_next = live_dec;
                            end
                        end
                        OP_FIRST, OP_NEXT:
                        begin
                            if ((live_reg != '0) && !cmd_reg.scan_none && fin_reg.found)
                            begin
                                rsp_next.result_id = FIELD_W'(fin_reg.id);
                            end
                        end
                        default:
                        begin
                            rsp_next.result_id = '0;
                        end
                    endcase
                    rsp_next.live_count = FIELD_W'(live_next);
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        fin_reg <= fin_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ tb/alloc_reply_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the slot identifier allocator: tracks occupancy, predicts and checks reply words.
module alloc_reply_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  sia_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  sia_pkg::rsp_t rsp,
    output int            failures,
    output int            pending
);
    import sia_pkg::*;

    logic               occupied [1:SLOTS];
    logic [FIELD_W-1:0] in_use;
    rsp_t               replies_due [$];
    rsp_t               want;

    function automatic logic [FIELD_W-1:0] lowest_taken(input int start);
        if (in_use == 0)
        begin
            return '0;
        end
        for (int i = (start < 1) ? 1 : start; i <= SLOTS; i++)
        begin
            if (occupied[i])
            begin
                return FIELD_W'(i);
            end
        end
        return '0;
    endfunction

    function automatic logic [FIELD_W-1:0] claim_slot();
        logic [FIELD_W-1:0] pick;
        pick = '0;
        if (in_use >= FIELD_W'(SLOTS))
        begin
            return '0;
        end
        if (in_use > 0 && !occupied[in_use])
        begin
            pick = in_use;
        end
        else
        begin
            for (int i = SLOTS; i >= 1; i--)
            begin
                if (!occupied[i])
                begin
                    pick = FIELD_W'(i);
                end
            end
        end
        occupied[pick] = 1'b1;
        in_use = in_use + FIELD_W'(1);
        return pick;
    endfunction

    function automatic rsp_t reply_for(input req_t r);
        rsp_t reply;
        reply.result_id = '0;
        case (r.operation)
            OP_ALLOC:
            begin
                reply.result_id = claim_slot();
            end
            OP_FREE:
            begin
                if (r.entity_index != 0 && r.entity_index <= FIELD_W'(SLOTS))
                begin
                    if (occupied[r.entity_index])
                    begin
                        occupied[r.entity_index] = 1'b0;
                        in_use = in_use - FIELD_W'(1);
                    end
                end
            end
            OP_FIRST:
            begin
                reply.result_id = lowest_taken(1);
            end
            default:
            begin
                reply.result_id = lowest_taken(int'(r.entity_index) + 1);
            end
        endcase
        reply.live_count = in_use;
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= SLOTS; i++)
            begin
                occupied[i] = 1'b0;
            end
            in_use = '0;
            replies_due.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    failures++;
                    $error("unexpected reply word: result_id %0d live_count %0d",
                           rsp.result_id, rsp.live_count);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp.result_id !== want.result_id)
                    begin
                        failures++;
                        $error("result_id: expected %0d, got %0d", want.result_id, rsp.result_id);
                    end
                    if (rsp.live_count !== want.live_count)
                    begin
                        failures++;
                        $error("live_count: expected %0d, got %0d",
                               want.live_count, rsp.live_count);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                replies_due.push_back(reply_for(req));
            end
            pending = replies_due.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the slot identifier allocator testbench: clock, reset, request and reply traffic, verdict.
module tb;
    import sia_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;
    int   failures;
    int   pending;
    int   burst_left   = 0;
    bit   hold_replies = 1'b0;

    slot_id_allocator dut (.*);

    alloc_reply_checker scoreboard (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [FIELD_W-1:0] any_index();
        if ($urandom_range(0, 15) == 0)
        begin
            return FIELD_W'($urandom_range(SLOTS + 1, 511));
        end
        return FIELD_W'($urandom_range(0, SLOTS));
    endfunction

    function automatic op_t mix_op(input int alloc_pct, input int free_pct, input int first_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
        begin
            return OP_ALLOC;
        end
        if (roll < alloc_pct + free_pct)
        begin
            return OP_FREE;
        end
        if (roll < alloc_pct + free_pct + first_pct)
        begin
            return OP_FIRST;
        end
        return OP_NEXT;
    endfunction

    task automatic offer_word(input op_t op, input logic [FIELD_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        req_valid          = 1'b1;
        req.operation      = op;
        req.entity_index   = idx;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        @(negedge clk);
    endtask

    initial
    begin
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 40);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_replies)
                begin
                    rsp_ready = 1'b0;
                    repeat (400) @(negedge clk);
                    hold_replies = 1'b0;
                end
                case (mode)
                    0: rsp_ready = 1'b1;
                    1: rsp_ready = ($urandom_range(0, 1) == 1);
                    default: rsp_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        offer_word(OP_FIRST, '0);
        offer_word(OP_NEXT, '0);
        offer_word(OP_FREE, '0);
        offer_word(OP_FREE, 9'd256);
        offer_word(OP_FREE, 9'd511);
        repeat (6) offer_word(OP_ALLOC, '0);
        offer_word(OP_FREE, 9'd1);
        offer_word(OP_FREE, 9'd4);
        offer_word(OP_ALLOC, 9'd511);
        offer_word(OP_FIRST, 9'd511);
        offer_word(OP_NEXT, '0);
        offer_word(OP_NEXT, 9'd2);
        offer_word(OP_NEXT, 9'd6);
        offer_word(OP_NEXT, 9'd255);
        offer_word(OP_NEXT, 9'd256);
        offer_word(OP_NEXT, 9'd511);
        offer_word(OP_FREE, 9'd1);

        repeat (200) offer_word(mix_op(50, 20, 10), any_index());

        req_valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
        burst_left = 0;

        hold_replies = 1'b1;
        repeat (300) offer_word(OP_ALLOC, any_index());
        repeat (250) offer_word(mix_op(15, 50, 10), any_index());

        req_valid = 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (failures == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
